FILE: rtl/agsf_pkg.sv
// Shared types, widths and score helpers for the affine-gap score fill block.
// Used by agsf_cell_calc, agsf_row_mem users and the top level.
// No dependencies.
package agsf_pkg;

  localparam int unsigned ScoreW     = 24;
  localparam int unsigned SubW       = 12;
  localparam int unsigned PenW       = 12;
  localparam int unsigned RowW       = 16;
  localparam int unsigned ColW       = 11;
  localparam int unsigned ProdW      = 28;
  localparam int unsigned SatW       = 26;
  localparam int unsigned ApbAddrW   = 5;
  localparam int unsigned ApbDataW   = 32;
  localparam int unsigned MaxColsDef = 1024;

  localparam logic signed [SatW-1:0] SatHi = 26'sd8388607;
  localparam logic signed [SatW-1:0] SatLo = -26'sd8388608;
  localparam logic [ScoreW-1:0]      ScoreMinBits = 24'h800000;

  typedef enum logic [2:0] {
    RegGapOpen   = 3'd0,
    RegGapExtend = 3'd1,
    RegEndFree   = 3'd2,
    RegRowCount  = 3'd3,
    RegColCount  = 3'd4
  } reg_idx_e;

  // Per-cell position and end-gap flags handed from the sequencer to the cell datapath
  typedef struct packed {
    logic first_row;
    logic first_col;
    logic free_ends;
  } cell_ctl_t;

  function automatic logic signed [ScoreW-1:0] sat_score(input logic signed [SatW-1:0] x);
    logic signed [ScoreW-1:0] r;
    if (x > SatHi) begin
      r = SatHi[ScoreW-1:0];
    end else if (x < SatLo) begin
      r = SatLo[ScoreW-1:0];
    end else begin
      r = x[ScoreW-1:0];
    end
    return r;
  endfunction

  // -(open + prod), clamped at the most negative score
  function automatic logic signed [ScoreW-1:0] boundary_score(input logic [PenW-1:0] open,
                                                              input logic [ProdW-1:0] prod);
    logic [ProdW:0]           sum;
    logic signed [ScoreW-1:0] r;
    sum = {{(ProdW+1-PenW){1'b0}}, open} + {1'b0, prod};
    if (sum > (ProdW+1)'(8388608)) begin
      r = ScoreMinBits;
    end else begin
      r = ~sum[ScoreW-1:0] + ScoreW'(1);
    end
    return r;
  endfunction

endpackage

FILE: rtl/affine_gap_alignment_score_fill_core.sv
// Affine-gap (Gotoh) global alignment score fill, one matrix cell per item.
// Depends on agsf_pkg, agsf_row_mem and agsf_cell_calc.
//
// Cells enter in row-major order, one substitution score per item, and leave
// with their best score, row, column and an end-of-matrix flag. The block
// takes one item per cycle unless the input stalls; an accepted item passes
// through the cell stage and then the output register, from which it leaves.
// The input stalls only while the cell stage and the output register both
// hold an item and the output is stalled. The figure is set by the row
// store, a MAX_COLS x 48-bit memory read once and written once per cell:
// each cell reads its column at acceptance and writes it back when it
// leaves the cell stage, and a read that meets the write of the cell just
// ahead (a one-column matrix) takes the new values from a forwarding
// register. Boundary scores come from two small multipliers on the row and
// column index. The row store needs no clearing pass after reset: row 1
// never uses the data it reads. Registers sit on an APB port at byte
// addresses 0, 4, 8, 12 and 16 and should be written only while the
// block is idle.
module affine_gap_alignment_score_fill_core
  import agsf_pkg::*;
#(
  parameter int unsigned MAX_COLS = MaxColsDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic signed [SubW-1:0]   sub_score_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [ScoreW-1:0] cell_score_o,
  output logic [RowW-1:0]          row_index_o,
  output logic [ColW-1:0]          col_index_o,
  output logic                     last_o,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [ApbAddrW-1:0]      paddr,
  input  logic [ApbDataW-1:0]      pwdata,
  output logic [ApbDataW-1:0]      prdata,
  output logic                     pready
);

  localparam int unsigned AW        = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int unsigned EntryW    = 2 * ScoreW;
  localparam int unsigned ColLimit  = (MAX_COLS > 2047) ? 2047 : MAX_COLS;
  localparam logic [ColW-1:0] ColLimitW = ColW'(ColLimit);
  localparam logic [AW-1:0]   LastSlot  = AW'(MAX_COLS - 1);

  // Configuration registers
  logic [PenW-1:0] gap_open_q, gap_extend_q;
  logic            end_free_q;
  logic [RowW-1:0] row_count_q;
  logic [ColW-1:0] col_count_q;
  logic            cfg_wr;
  reg_idx_e        cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_open_q   <= PenW'(16);
      gap_extend_q <= PenW'(8);
      end_free_q   <= 1'b0;
      row_count_q  <= RowW'(1);
      col_count_q  <= ColW'(1024);
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        RegGapOpen:   gap_open_q   <= pwdata[PenW-1:0];
        RegGapExtend: gap_extend_q <= pwdata[PenW-1:0];
        RegEndFree:   end_free_q   <= pwdata[0];
        RegRowCount:  row_count_q  <= pwdata[RowW-1:0];
        RegColCount:  col_count_q  <= pwdata[ColW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      RegGapOpen:   prdata = ApbDataW'(gap_open_q);
      RegGapExtend: prdata = ApbDataW'(gap_extend_q);
      RegEndFree:   prdata = ApbDataW'(end_free_q);
      RegRowCount:  prdata = ApbDataW'(row_count_q);
      RegColCount:  prdata = ApbDataW'(col_count_q);
      default:      prdata = '0;
    endcase
  end

  // Handshake and pipeline control
  logic in_acc, out_free, s1_move;
  logic s1_valid_q, out_valid_q;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_move    = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;

  // Position sequencer
  logic [RowW-1:0] cur_row_q, nrows;
  logic [ColW-1:0] cur_col_q, ncols, col_m1;
  logic            row_end, last_cell;
  logic [AW-1:0]   slot_d;

  assign nrows = (row_count_q == '0) ? RowW'(1) : row_count_q;

  always_comb begin
    ncols = (col_count_q == '0) ? ColW'(1) : col_count_q;
    if (ncols > ColLimitW) begin
      ncols = ColLimitW;
    end
  end

  assign row_end   = cur_col_q >= ncols;
  assign last_cell = row_end && (cur_row_q >= nrows);
  assign col_m1    = cur_col_q - ColW'(1);
  assign slot_d    = (32'(col_m1) >= MAX_COLS) ? LastSlot : AW'(col_m1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_row_q <= RowW'(1);
      cur_col_q <= ColW'(1);
    end else if (in_acc) begin
      if (last_cell) begin
        cur_row_q <= RowW'(1);
        cur_col_q <= ColW'(1);
      end else if (row_end) begin
        cur_row_q <= cur_row_q + RowW'(1);
        cur_col_q <= ColW'(1);
      end else begin
        cur_col_q <= cur_col_q + ColW'(1);
      end
    end
  end

  // Stage 1: cell held while its row store entry is read
  logic signed [SubW-1:0]   s1_sub_q;
  logic [RowW-1:0]          s1_row_q;
  logic [ColW-1:0]          s1_col_q;
  logic [AW-1:0]            s1_slot_q;
  logic                     s1_last_q;
  cell_ctl_t                s1_ctl_q;
  logic [ProdW-1:0]         row_prod_q, col_prod_q, row_prod_d, col_prod_d;
  logic                     fwd_q, fwd_d;
  logic signed [ScoreW-1:0] fwd_best_q, fwd_vgap_q;
  logic signed [ScoreW-1:0] left_best_q, left_hgap_q, diag_best_q;
  logic signed [ScoreW-1:0] best, hgap, vgap, above_best;
  logic signed [ScoreW-1:0] mem_best, mem_vgap;
  logic [EntryW-1:0]        rd_data;

  assign row_prod_d = ProdW'(cur_row_q) * ProdW'(gap_extend_q);
  assign col_prod_d = ProdW'(cur_col_q) * ProdW'(gap_extend_q);
  // the cell ahead writes this column at the same edge as our read
  assign fwd_d      = s1_move && (s1_slot_q == slot_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_move) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_sub_q            <= sub_score_i;
      s1_row_q            <= cur_row_q;
      s1_col_q            <= cur_col_q;
      s1_slot_q           <= slot_d;
      s1_last_q           <= last_cell;
      s1_ctl_q.first_row  <= cur_row_q == RowW'(1);
      s1_ctl_q.first_col  <= cur_col_q == ColW'(1);
      s1_ctl_q.free_ends  <= end_free_q;
      row_prod_q          <= row_prod_d;
      col_prod_q          <= col_prod_d;
      fwd_q               <= fwd_d;
      fwd_best_q          <= best;
      fwd_vgap_q          <= vgap;
    end
  end

  agsf_row_mem #(
    .DEPTH (MAX_COLS),
    .WIDTH (EntryW)
  ) u_row_mem (
    .clk_i     (clk_i),
    .wr_en_i   (s1_move),
    .wr_addr_i (s1_slot_q),
    .wr_data_i ({best, vgap}),
    .rd_en_i   (in_acc),
    .rd_addr_i (slot_d),
    .rd_data_o (rd_data)
  );

  assign mem_best = fwd_q ? fwd_best_q : rd_data[EntryW-1:ScoreW];
  assign mem_vgap = fwd_q ? fwd_vgap_q : rd_data[ScoreW-1:0];

  agsf_cell_calc u_cell_calc (
    .ctl_i        (s1_ctl_q),
    .sub_score_i  (s1_sub_q),
    .gap_open_i   (gap_open_q),
    .gap_extend_i (gap_extend_q),
    .row_prod_i   (row_prod_q),
    .col_prod_i   (col_prod_q),
    .left_best_i  (left_best_q),
    .left_hgap_i  (left_hgap_q),
    .diag_best_i  (diag_best_q),
    .mem_best_i   (mem_best),
    .mem_vgap_i   (mem_vgap),
    .best_o       (best),
    .hgap_o       (hgap),
    .vgap_o       (vgap),
    .above_best_o (above_best)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_best_q <= '0;
      left_hgap_q <= '0;
      diag_best_q <= '0;
    end else if (s1_move) begin
      left_best_q <= best;
      left_hgap_q <= hgap;
      diag_best_q <= above_best;
    end
  end

  // Output register
  logic signed [ScoreW-1:0] out_score_q;
  logic [RowW-1:0]          out_row_q;
  logic [ColW-1:0]          out_col_q;
  logic                     out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      out_score_q <= best;
      out_row_q   <= s1_row_q;
      out_col_q   <= s1_col_q;
      out_last_q  <= s1_last_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign cell_score_o = out_score_q;
  assign row_index_o  = out_row_q;
  assign col_index_o  = out_col_q;
  assign last_o       = out_last_q;

endmodule

FILE: rtl/agsf_row_mem.sv
// Row store: one write port and one read port, read data registered.
// Holds the previous row's best and vertical-gap scores per column.
// Depends on nothing but its parameters.
module agsf_row_mem #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 48,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: rtl/agsf_cell_calc.sv
// Gotoh recurrence for one cell: boundary generation, g/e/f terms and best score.
// Depends on agsf_pkg for widths, cell_ctl_t and the saturation helpers.
module agsf_cell_calc
  import agsf_pkg::*;
(
  input  cell_ctl_t                ctl_i,
  input  logic signed [SubW-1:0]   sub_score_i,
  input  logic [PenW-1:0]          gap_open_i,
  input  logic [PenW-1:0]          gap_extend_i,
  input  logic [ProdW-1:0]         row_prod_i,
  input  logic [ProdW-1:0]         col_prod_i,
  input  logic signed [ScoreW-1:0] left_best_i,
  input  logic signed [ScoreW-1:0] left_hgap_i,
  input  logic signed [ScoreW-1:0] diag_best_i,
  input  logic signed [ScoreW-1:0] mem_best_i,
  input  logic signed [ScoreW-1:0] mem_vgap_i,
  output logic signed [ScoreW-1:0] best_o,
  output logic signed [ScoreW-1:0] hgap_o,
  output logic signed [ScoreW-1:0] vgap_o,
  output logic signed [ScoreW-1:0] above_best_o
);

  logic signed [ScoreW-1:0] bnd_row, bnd_row_prev, bnd_col;
  logic signed [ScoreW-1:0] lb, lh, dg, ab, av, g, e, f;
  logic signed [SatW-1:0]   open_s, ext_s, e_max, f_max, lb_open, ab_open;
  logic [ProdW-1:0]         row_prev_prod;

  assign open_s        = SatW'(gap_open_i);
  assign ext_s         = SatW'(gap_extend_i);
  assign row_prev_prod = row_prod_i - ProdW'(gap_extend_i);

  always_comb begin
    if (ctl_i.free_ends) begin
      bnd_row      = '0;
      bnd_row_prev = '0;
      bnd_col      = '0;
    end else begin
      bnd_row      = boundary_score(gap_open_i, row_prod_i);
      bnd_row_prev = boundary_score(gap_open_i, row_prev_prod);
      bnd_col      = boundary_score(gap_open_i, col_prod_i);
    end
  end

  always_comb begin
    if (ctl_i.first_col) begin
      lb = bnd_row;
      lh = bnd_row;
      // corner cell takes a zero diagonal
      dg = ctl_i.first_row ? '0 : bnd_row_prev;
    end else begin
      lb = left_best_i;
      lh = left_hgap_i;
      dg = diag_best_i;
    end
    if (ctl_i.first_row) begin
      ab = bnd_col;
      av = bnd_col;
    end else begin
      ab = mem_best_i;
      av = mem_vgap_i;
    end
  end

  assign lb_open = SatW'(lb) - open_s;
  assign ab_open = SatW'(ab) - open_s;
  assign e_max   = (SatW'(lh) > lb_open) ? SatW'(lh) : lb_open;
  assign f_max   = (SatW'(av) > ab_open) ? SatW'(av) : ab_open;

  assign g = sat_score(SatW'(dg) + SatW'(sub_score_i));
  assign e = sat_score(e_max - ext_s);
  assign f = sat_score(f_max - ext_s);

  always_comb begin
    best_o = g;
    if (e > best_o) begin
      best_o = e;
    end
    if (f > best_o) begin
      best_o = f;
    end
  end

  assign hgap_o       = e;
  assign vgap_o       = f;
  assign above_best_o = ab;

endmodule

FILE: rtl/agsf_checker.sv
// Port-level checks for the affine-gap score fill core, bound to the top level.
// Depends on agsf_pkg for port widths.
module agsf_checker
  import agsf_pkg::*;
(
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_stall_o,
  input logic                     out_valid_o,
  input logic                     out_stall_i,
  input logic signed [ScoreW-1:0] cell_score_o,
  input logic [RowW-1:0]          row_index_o,
  input logic [ColW-1:0]          col_index_o,
  input logic                     last_o
);

  // input side backs up only behind a full, stalled output
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled while output can drain");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("output item dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      ($stable(cell_score_o) && $stable(row_index_o) && $stable(col_index_o) && $stable(last_o)))
    else $error("stalled output item changed");

  a_pos_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((row_index_o != '0) && (col_index_o != '0)))
    else $error("cell position counts from one");

endmodule

bind affine_gap_alignment_score_fill_core agsf_checker u_agsf_checker (.*);

FILE: dv/affine_gap_alignment_score_fill_core_tb.sv
// Self-checking testbench for the affine-gap alignment score fill core.
// Depends on agsf_pkg and the core RTL; scores each cell in a local model
// and checks every result item, with APB setup between matrices.
module affine_gap_alignment_score_fill_core_tb;
  import agsf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaxCols    = MaxColsDef;
  localparam int unsigned NumRegs    = 5;
  localparam int unsigned RandCells  = 520;
  localparam int unsigned QuietLimit = 3000;
  localparam time         ClkPeriod  = 10ns;
  localparam longint      ScoreTop   = 8388607;
  localparam longint      ScoreFloor = -8388608;

  localparam logic signed [SubW-1:0] SubMin = {1'b1, {(SubW-1){1'b0}}};
  localparam logic signed [SubW-1:0] SubMax = ~SubMin;

  typedef struct {
    logic signed [ScoreW-1:0] score;
    logic [RowW-1:0]          row;
    logic [ColW-1:0]          col;
    logic                     last;
  } cell_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     in_valid_i = 1'b0;
  logic                     in_stall_o;
  logic signed [SubW-1:0]   sub_score_i = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic signed [ScoreW-1:0] cell_score_o;
  logic [RowW-1:0]          row_index_o;
  logic [ColW-1:0]          col_index_o;
  logic                     last_o;
  logic                     psel = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite = 1'b0;
  logic [ApbAddrW-1:0]      paddr = '0;
  logic [ApbDataW-1:0]      pwdata = '0;
  logic [ApbDataW-1:0]      prdata;
  logic                     pready;

  affine_gap_alignment_score_fill_core i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .sub_score_i  (sub_score_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .cell_score_o (cell_score_o),
    .row_index_o  (row_index_o),
    .col_index_o  (col_index_o),
    .last_o       (last_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // Local copy of the register file
  logic [PenW-1:0] cfg_open   = 12'd16;
  logic [PenW-1:0] cfg_extend = 12'd8;
  logic            cfg_free   = 1'b0;
  logic [RowW-1:0] cfg_rows   = 16'd1;
  logic [ColW-1:0] cfg_cols   = 11'd1024;

  // Fill state: previous row, left neighbor, diagonal, position
  longint      prev_row_best [MaxCols];
  longint      prev_row_vgap [MaxCols];
  longint      west_best = 0;
  longint      west_hgap = 0;
  longint      nw_best = 0;
  int unsigned pos_row = 1;
  int unsigned pos_col = 1;
  int unsigned store_fill = 0;  // row store slots written so far, always a prefix

  logic signed [SubW-1:0] cells_to_send [$];
  cell_t                  expected_cells [$];

  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned cells_queued = 0;
  int unsigned cells_taken = 0;
  int unsigned cells_checked = 0;
  int unsigned matrices_done = 0;
  int unsigned floor_cells = 0;
  int unsigned reg_writes = 0;
  int unsigned mid_changes = 0;
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;
  bit          in_fired = 1'b0;

  function automatic longint clamp_score(input longint x);
    if (x > ScoreTop) return ScoreTop;
    if (x < ScoreFloor) return ScoreFloor;
    return x;
  endfunction

  function automatic longint border_score(input int unsigned k);
    if (cfg_free) return 0;
    return clamp_score(-(longint'(cfg_open) + longint'(k) * longint'(cfg_extend)));
  endfunction

  function automatic int unsigned limit_cols(input logic [ColW-1:0] c);
    int unsigned n;
    n = (c == 0) ? 1 : c;
    return (n > MaxCols) ? MaxCols : n;
  endfunction

  // Cells still to come until the current matrix ends, under the current setup
  function automatic int unsigned cells_left();
    int unsigned nr, nc, row_left;
    nr = (cfg_rows == 0) ? 1 : cfg_rows;
    nc = limit_cols(cfg_cols);
    row_left = (pos_col >= nc) ? 1 : nc - pos_col + 1;
    return (pos_row >= nr) ? row_left : row_left + (nr - pos_row) * nc;
  endfunction

  task automatic score_cell(input logic signed [SubW-1:0] sub);
    int unsigned nr, nc, slot;
    longint      lb, lh, ab, av, dg, g, e, f, v, op, ex;
    bit          row_end;
    cell_t       c;
    nr = (cfg_rows == 0) ? 1 : cfg_rows;
    nc = limit_cols(cfg_cols);
    op = longint'(cfg_open);
    ex = longint'(cfg_extend);
    slot = (pos_col - 1 >= MaxCols) ? MaxCols - 1 : pos_col - 1;
    if (pos_col == 1) begin
      lb = border_score(pos_row);
      lh = lb;
      dg = (pos_row == 1) ? 0 : border_score(pos_row - 1);
    end else begin
      lb = west_best;
      lh = west_hgap;
      dg = nw_best;
    end
    if (pos_row == 1) begin
      ab = border_score(pos_col);
      av = ab;
    end else begin
      ab = prev_row_best[slot];
      av = prev_row_vgap[slot];
    end
    g = clamp_score(dg + longint'(sub));
    e = clamp_score(((lh > lb - op) ? lh : lb - op) - ex);
    f = clamp_score(((av > ab - op) ? av : ab - op) - ex);
    v = (g > e) ? g : e;
    v = (f > v) ? f : v;
    prev_row_best[slot] = v;
    prev_row_vgap[slot] = f;
    if (slot + 1 > store_fill) store_fill = slot + 1;
    west_best = v;
    west_hgap = e;
    nw_best = ab;
    row_end = pos_col >= nc;
    c.score = ScoreW'(v);
    c.row = RowW'(pos_row);
    c.col = ColW'(pos_col);
    c.last = row_end && pos_row >= nr;
    if (v == ScoreFloor) floor_cells++;
    expected_cells.push_back(c);
    if (c.last) begin
      pos_row = 1;
      pos_col = 1;
    end else if (row_end) begin
      pos_row++;
      pos_col = 1;
    end else begin
      pos_col++;
    end
  endtask

  // Accept items, predict, check results, watch for a hang
  always @(posedge clk_i) begin : monitor
    cell_t want;
    bit    out_fired;
    if (!rst_ni) begin
      in_fired = 1'b0;
    end else begin
      in_fired = in_valid_i && !in_stall_o;
      out_fired = out_valid_o && !out_stall_i;
      if (in_fired) begin
        score_cell(sub_score_i);
        cells_taken++;
      end
      if (out_fired) begin
        if (expected_cells.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected item: expected none, actual %0d %0d %0d %0b",
                   $realtime, cell_score_o, row_index_o, col_index_o, last_o);
        end else begin
          want = expected_cells.pop_front();
          cells_checked++;
          if (want.last) matrices_done++;
          if (cell_score_o !== want.score || row_index_o !== want.row ||
              col_index_o !== want.col || last_o !== want.last) begin
            mismatches++;
            $display("%0t: mismatch: expected %0d %0d %0d %0b, actual %0d %0d %0d %0b",
                     $realtime, want.score, want.row, want.col, want.last,
                     cell_score_o, row_index_o, col_index_o, last_o);
          end
        end
      end
      quiet_cycles = (in_fired || out_fired) ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= QuietLimit) begin
        $display("%0t: no item moved for %0d cycles", $realtime, QuietLimit);
        $display("affine_gap_alignment_score_fill_core test failed");
        $finish;
      end
    end
  end

  // Sender: hold the item while stalled, otherwise advance or idle
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_fired)) begin
      if (cells_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid_i  <= 1'b1;
        sub_score_i <= cells_to_send.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    out_stall_i <= rst_ni && ($urandom_range(99) < stall_pct);
  end

  task automatic queue_cell(input logic signed [SubW-1:0] s);
    cells_to_send.push_back(s);
    cells_queued++;
  endtask

  task automatic queue_random_cells(input int unsigned count);
    logic signed [SubW-1:0] s;
    repeat (count) begin
      case ($urandom_range(7))
        0:       s = SubMin;
        1:       s = SubMax;
        default: s = SubW'($urandom_range(4095));
      endcase
      queue_cell(s);
    end
  endtask

  // Wait until every queued item is taken and every result has come
  task automatic wait_idle();
    do @(negedge clk_i);
    while (cells_taken != cells_queued || expected_cells.size() != 0);
  endtask

  // APB write followed by a read back of the same address
  task automatic write_reg(input logic [2:0] idx, input logic [ApbDataW-1:0] value);
    logic [ApbDataW-1:0] stored;
    logic [ApbDataW-1:0] readback;
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ApbAddrW'({idx, 2'b00});
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    readback = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    reg_writes++;
    stored = '0;
    case (idx)
      RegGapOpen:   begin cfg_open = value[PenW-1:0];   stored = ApbDataW'(cfg_open);   end
      RegGapExtend: begin cfg_extend = value[PenW-1:0]; stored = ApbDataW'(cfg_extend); end
      RegEndFree:   begin cfg_free = value[0];          stored = ApbDataW'(cfg_free);   end
      RegRowCount:  begin cfg_rows = value[RowW-1:0];   stored = ApbDataW'(cfg_rows);   end
      RegColCount:  begin cfg_cols = value[ColW-1:0];   stored = ApbDataW'(cfg_cols);   end
      default: ;
    endcase
    if (idx < NumRegs && readback !== stored) begin
      mismatches++;
      $display("%0t: register %0d read back: expected %0h, actual %0h",
               $realtime, idx, stored, readback);
    end
  endtask

  task automatic randomize_setup();
    wait_idle();
    case ($urandom_range(3))
      0:       write_reg(RegGapOpen, 0);
      1:       write_reg(RegGapOpen, 4095);
      2:       write_reg(RegGapOpen, $urandom_range(4095));
      default: write_reg(RegGapOpen, $urandom_range(96));
    endcase
    case ($urandom_range(3))
      0:       write_reg(RegGapExtend, 0);
      1:       write_reg(RegGapExtend, 4095);
      2:       write_reg(RegGapExtend, $urandom_range(4095));
      default: write_reg(RegGapExtend, $urandom_range(48));
    endcase
    write_reg(RegEndFree, $urandom_range(1));
    write_reg(RegRowCount, $urandom_range(6));
    write_reg(RegColCount, ($urandom_range(7) == 0) ? $urandom_range(80, 13)
                                                    : $urandom_range(12));
  endtask

  initial begin : stimulus
    int unsigned mode_cells, n, first, new_cols;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Corner cell and field extremes with charged end gaps
    write_reg(RegGapOpen, 16);
    write_reg(RegGapExtend, 8);
    write_reg(RegEndFree, 0);
    write_reg(RegRowCount, 2);
    write_reg(RegColCount, 3);
    queue_cell(SubMax);
    queue_cell(SubMin);
    queue_cell(SubW'(0));
    queue_cell(SubW'(1));
    queue_cell(SubW'(-1));
    queue_cell(SubMax);

    // Free end gaps, zero counts act as one, two matrices back to back
    wait_idle();
    write_reg(RegEndFree, 1);
    write_reg(RegRowCount, 0);
    write_reg(RegColCount, 0);
    queue_cell(SubMin);
    queue_cell(SubMax);

    // Unused addresses are ignored; bits above each register's width drop
    wait_idle();
    for (int unsigned idx = NumRegs; idx < 8; idx++) write_reg(3'(idx), '1);
    write_reg(RegGapOpen, 32'hFFFF_FFFF);
    write_reg(RegGapExtend, 32'hFFFF_FFFF);
    write_reg(RegEndFree, 32'hFFFF_FFFE);
    write_reg(RegRowCount, 32'h0001_0002);
    write_reg(RegColCount, 32'hFFFF_F802);
    queue_random_cells(4);

    // Counts changed mid-matrix: position already at or past both new counts
    wait_idle();
    write_reg(RegGapOpen, 0);
    write_reg(RegGapExtend, 0);
    write_reg(RegRowCount, 16'hFFFF);
    write_reg(RegColCount, 3);
    queue_random_cells(4);
    wait_idle();
    write_reg(RegColCount, 1);
    write_reg(RegRowCount, 2);
    mid_changes++;
    queue_random_cells(cells_left());

    // Column count above the row store: acts as its full width
    wait_idle();
    write_reg(RegGapOpen, 30);
    write_reg(RegGapExtend, 3);
    write_reg(RegEndFree, 0);
    write_reg(RegRowCount, 1);
    write_reg(RegColCount, 2047);
    queue_random_cells(cells_left());

    // Tall single column with the largest penalties, every cell after the first forwarded
    wait_idle();
    write_reg(RegGapOpen, 4095);
    write_reg(RegGapExtend, 4095);
    write_reg(RegRowCount, 40);
    write_reg(RegColCount, 1);
    queue_random_cells(cells_left());

    for (int mode = 0; mode < 4; mode++) begin
      wait_idle();
      case (mode)
        0:       begin send_idle_pct = 0;  stall_pct = 0;  end
        1:       begin send_idle_pct = 79; stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  stall_pct = 79; end
        default: begin send_idle_pct = 34; stall_pct = 34; end
      endcase
      mode_cells = 0;
      while (mode_cells < RandCells / 4) begin
        // Matrices always queue whole, so a new one starts at the first cell
        if (mode_cells == 0 || $urandom_range(1) == 0) randomize_setup();
        n = cells_left();
        if (n > 1 && $urandom_range(5) == 0) begin
          first = n / 2;
          queue_random_cells(first);
          wait_idle();
          write_reg(RegRowCount, $urandom_range(6));
          new_cols = $urandom_range(12);
          // Past the first row, grow columns only over row store slots that hold data
          if (pos_row == 1 || limit_cols(ColW'(new_cols)) <= store_fill) begin
            write_reg(RegColCount, new_cols);
          end
          mid_changes++;
          n = cells_left();
          queue_random_cells(n);
          mode_cells += first + n;
        end else begin
          queue_random_cells(n);
          mode_cells += n;
        end
      end
    end

    wait_idle();
    repeat (20) @(posedge clk_i);
    $display("Checked %0d cells in %0d matrices over four idle/stall mixes, %0d register writes.",
             cells_checked, matrices_done, reg_writes);
    $display("Included %0d mid-matrix count changes and %0d cells at the score floor.",
             mid_changes, floor_cells);
    if (mismatches == 0) begin
      $display("affine_gap_alignment_score_fill_core test passed");
    end else begin
      $display("affine_gap_alignment_score_fill_core test failed");
    end
    $finish;
  end

endmodule
